// File: design/hafc_pkg.sv
// ----------------------------------------------------------------------------
// hafc_pkg
// Shared constants and helper functions for the hex ASCII frame checker.
// ----------------------------------------------------------------------------
package hafc_pkg;

  localparam int unsigned MAX_CHARS_DEF = 256;

  localparam logic [7:0]  START_RST  = 8'hAA;
  localparam logic [7:0]  END_RST    = 8'h55;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  ASCII_ZERO = 8'h30;
  localparam logic [7:0]  ALPHA_GAP  = 8'h07;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  localparam logic REG_START = 1'b0;
  localparam logic REG_END   = 1'b1;

  localparam int unsigned OUT_BITS  = 26;
  localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;

  // full 8-bit digit value; non-hex characters carry into the byte sum
  function automatic logic [7:0] nibble_of(input logic [7:0] c);
    logic [7:0] s;
    s = c - ASCII_ZERO;
    if (s > 8'd9) begin
      s = s - ALPHA_GAP;
    end
    return s;
  endfunction

  // byte-wide CRC-16/Modbus, reflected
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: design/hex_ascii_frame_checker_core.sv
// ----------------------------------------------------------------------------
// hex_ascii_frame_checker_core
// Decodes hex text into bytes, runs CRC-16/Modbus and checks frame layout.
// ----------------------------------------------------------------------------
// Channel | Direction | Beat contents
// in_     | slave     | tdata[7:0] char_in
// out_    | master    | tdata[1:0] status, [9:2] frame_bytes, [25:10] crc_value
// cfg_    | APB       | 0x0 start_value, 0x4 end_value
//
// One character per cycle, save where the terminating zero stalls; a beat moves
// from the input register to the frame state; the zero loads the result register.
// The frame state update (nibble decode, one byte of CRC) sets the cycle time.
// Only the terminating zero character waits on a full result register.
// rst_n is synchronous; reset restores the register defaults and clears the frame.
// ----------------------------------------------------------------------------
module hex_ascii_frame_checker_core
  import hafc_pkg::*;
#(
  parameter int unsigned MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] char_in
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [8*OUT_BYTES-1:0] out_tdata,  // [1:0] status, [9:2] frame_bytes,
                                             // [25:10] crc_value, rest zero
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [2:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  localparam int unsigned CW   = $clog2(MAX_CHARS + 1);
  localparam int unsigned LW   = CW - 1;
  localparam int unsigned CMPW = (LW > 8) ? LW : 8;

  logic [7:0] start_r, end_r;

  logic       in_vld_r;
  logic [7:0] in_char_r;

  logic [CW-1:0] char_count_r;
  logic [3:0]    high_nibble_r;
  logic [15:0]   crc_r;
  logic [7:0]    dly0_r, dly1_r, dly2_r;
  logic [7:0]    first_r, second_r;
  logic          ovf_r;

  logic          out_vld_r;
  logic [1:0]    status_r;
  logic [7:0]    frame_bytes_r;
  logic [15:0]   crc_out_r;

  logic          is_end, advance, full;
  logic [LW-1:0] idx;
  logic [7:0]    nib_val;
  logic [7:0]    byte_val;
  logic [CMPW-1:0] len_ext, second_ext;
  logic [1:0]    status_nxt;
  logic [7:0]    frame_bytes_nxt;
  logic          frame_ok;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {24'h0, (cfg_paddr[2] == REG_END) ? end_r : start_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_RST;
      end_r   <= END_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      if (cfg_paddr[2] == REG_START) begin
        start_r <= cfg_pwdata[7:0];
      end else begin
        end_r <= cfg_pwdata[7:0];
      end
    end
  end

  // datapath control
  assign is_end    = (in_char_r == 8'h00);
  assign advance   = in_vld_r && (!is_end || !out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
    end
  end

  assign full     = (char_count_r >= CW'(MAX_CHARS));
  assign idx      = char_count_r[CW-1:1];
  assign nib_val  = nibble_of(in_char_r);
  assign byte_val = {high_nibble_r, 4'h0} + nib_val;

  assign len_ext    = CMPW'(idx);
  assign second_ext = CMPW'(second_r);

  assign frame_ok = (first_r == start_r) && (second_ext == len_ext) &&
                    (dly2_r == crc_r[7:0]) && (dly1_r == crc_r[15:8]) &&
                    (dly0_r == end_r);

  always_comb begin
    if (ovf_r) begin
      status_nxt = ST_OVF;
    end else if (idx < LW'(3)) begin
      status_nxt = ST_FAIL;
    end else if (frame_ok) begin
      status_nxt = ST_OK;
    end else begin
      status_nxt = ST_FAIL;
    end
    if (len_ext > CMPW'(255)) begin
      frame_bytes_nxt = 8'hFF;
    end else begin
      frame_bytes_nxt = len_ext[7:0];
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n || (advance && is_end)) begin
      char_count_r  <= '0;
      high_nibble_r <= '0;
      crc_r         <= CRC_INIT;
      dly0_r        <= '0;
      dly1_r        <= '0;
      dly2_r        <= '0;
      first_r       <= '0;
      second_r      <= '0;
      ovf_r         <= 1'b0;
    end else if (advance) begin
      if (full) begin
        ovf_r <= 1'b1;
      end else begin
        char_count_r <= char_count_r + CW'(1);
        if (!char_count_r[0]) begin
          high_nibble_r <= nib_val[3:0];
        end else begin
          if (idx == LW'(0)) begin
            first_r <= byte_val;
          end
          if (idx == LW'(1)) begin
            second_r <= byte_val;
          end
          if (idx >= LW'(3)) begin
            crc_r <= crc_byte(crc_r, dly2_r);
          end
          dly2_r <= dly1_r;
          dly1_r <= dly0_r;
          dly0_r <= byte_val;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && is_end) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_end) begin
      status_r      <= status_nxt;
      frame_bytes_r <= frame_bytes_nxt;
      crc_out_r     <= crc_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(8*OUT_BYTES-OUT_BITS)'(0), crc_out_r, frame_bytes_r, status_r};

`ifndef ASSERT_OFF
  a_ovf_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (char_count_r == CW'(MAX_CHARS)))
    else $error("overflow flag set below capacity");

  a_short_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && frame_bytes_r < 8'd3) |-> (status_r == ST_FAIL && crc_out_r == CRC_INIT))
    else $error("short frame result inconsistent");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (status_r == ST_OK || status_r == ST_FAIL || status_r == ST_OVF))
    else $error("illegal status code");

  a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_end) |=> (char_count_r == '0 && !ovf_r && crc_r == CRC_INIT))
    else $error("frame state not cleared after end of frame");

  a_end_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && is_end && out_vld_r && !out_tready) |-> !advance)
    else $error("end of frame overwrote pending result");
`endif

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for hex_ascii_frame_checker_core. Drives hex text beats into the
// character stream, decodes and CRC-checks the same text in a local model,
// and compares every result beat field by field. It runs a directed table,
// then random frames (mostly well formed, some damaged, some noise, a few
// overflowing) under four register settings and four idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hafc_pkg::*;

  localparam int unsigned SETTLE      = 8;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned PHASE_CHARS = 240;
  localparam int          SCRIPT_LEN  = 25;
  localparam logic [2:0]  ADDR_START  = {REG_START, 2'b00};
  localparam logic [2:0]  ADDR_END    = {REG_END, 2'b00};

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  nbytes;
    logic [15:0] crc;
  } frame_verdict_t;

  typedef struct packed {
    logic [7:0]     ch;
    logic           known;
    frame_verdict_t v;
  } script_row_t;

  typedef enum int { FLAW_NONE, FLAW_BYTE, FLAW_CUT, FLAW_EXTRA } flaw_t;

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata    = 8'h00;   // [7:0] char_in
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [8*OUT_BYTES-1:0] out_tdata;             // [1:0] status, [9:2] frame_bytes,
                                                 // [25:10] crc_value
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [2:0]             cfg_paddr   = 3'd0;
  logic [31:0]            cfg_pwdata  = 32'd0;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  hex_ascii_frame_checker_core uut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // local copy of registers and frame state
  logic [7:0]  cfg_start = START_RST;
  logic [7:0]  cfg_end   = END_RST;
  int unsigned held      = 0;
  logic [7:0]  hi_nib    = 8'h00;
  logic [15:0] crc_acc   = CRC_INIT;
  logic [7:0]  tail [3]  = '{8'h00, 8'h00, 8'h00};
  logic [7:0]  byte0     = 8'h00;
  logic [7:0]  byte1     = 8'h00;
  logic        ovf       = 1'b0;

  frame_verdict_t verdict_q [$];
  logic [7:0]     line_buf [$];
  int unsigned    err_count  = 0;
  int unsigned    chars_sent = 0;
  int unsigned    quiet      = 0;
  int unsigned    src_idle   = 0;
  int unsigned    sink_stall = 0;

  script_row_t script [SCRIPT_LEN] = '{
    '{8'h00, 1'b1, '{ST_FAIL, 8'd0, CRC_INIT}},   // empty frame
    '{"F",   1'b0, '0},
    '{"F",   1'b0, '0},
    '{8'h00, 1'b1, '{ST_FAIL, 8'd1, CRC_INIT}},   // too short
    '{8'hFF, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h00, 1'b1, '{ST_FAIL, 8'd1, CRC_INIT}},
    '{"A",   1'b0, '0},
    '{"A",   1'b0, '0},
    '{"0",   1'b0, '0},
    '{"3",   1'b0, '0},
    '{"5",   1'b0, '0},
    '{"5",   1'b0, '0},
    '{8'h00, 1'b1, '{ST_FAIL, 8'd3, CRC_INIT}},   // 3 bytes, CRC field wrong
    '{"A",   1'b0, '0},
    '{"A",   1'b0, '0},
    '{"0",   1'b0, '0},
    '{"5",   1'b0, '0},
    '{"B",   1'b0, '0},
    '{"F",   1'b0, '0},
    '{"1",   1'b0, '0},
    '{"3",   1'b0, '0},
    '{"5",   1'b0, '0},
    '{"5",   1'b0, '0},
    '{8'h00, 1'b0, '0}                            // good frame
  };

  function automatic logic [7:0] hex_val(input logic [7:0] ch);
    logic [7:0] v;
    v = ch - ASCII_ZERO;
    return (v > 8'd9) ? v - ALPHA_GAP : v;
  endfunction

  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  // character that decodes to n; only the low nibble counts in the high position
  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper_half);
    logic [7:0]  c;
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 10) begin
      do c = 8'($urandom_range(255, 1));
      while (upper_half ? ((hex_val(c) & 8'h0F) != {4'h0, n}) : (hex_val(c) != {4'h0, n}));
    end else if (n < 4'd10) begin
      c = ASCII_ZERO + n;
    end else if (upper_half && roll < 40) begin
      c = ASCII_ZERO + ALPHA_GAP + 8'h20 + n;
    end else begin
      c = ASCII_ZERO + ALPHA_GAP + n;
    end
    return c;
  endfunction

  task automatic note_mismatch(input string msg);
    if (err_count < 50) $display("%0t mismatch: %s", $time, msg);
    err_count++;
  endtask

  task automatic clear_frame();
    held    = 0;
    hi_nib  = 8'h00;
    crc_acc = CRC_INIT;
    tail    = '{8'h00, 8'h00, 8'h00};
    byte0   = 8'h00;
    byte1   = 8'h00;
    ovf     = 1'b0;
  endtask

  task automatic absorb_char(input logic [7:0] ch, output logic done,
                             output frame_verdict_t v);
    logic [7:0]  b;
    int unsigned pairs;
    done = 1'b0;
    v    = '0;
    if (ch != 8'h00) begin
      if (held >= MAX_CHARS_DEF) begin
        ovf = 1'b1;
      end else begin
        if (held[0] == 1'b0) begin
          hi_nib = hex_val(ch);
        end else begin
          b     = (hi_nib << 4) + hex_val(ch);
          pairs = held >> 1;
          if (pairs == 0) byte0 = b;
          else if (pairs == 1) byte1 = b;
          if (pairs >= 3) crc_acc = crc_step(crc_acc, tail[2]);
          tail[2] = tail[1];
          tail[1] = tail[0];
          tail[0] = b;
        end
        held++;
      end
    end else begin
      pairs = held >> 1;
      done  = 1'b1;
      if (ovf) begin
        v.status = ST_OVF;
      end else if (pairs < 3) begin
        v.status = ST_FAIL;
      end else begin
        v.status = (byte0 == cfg_start && byte1 == pairs && tail[2] == crc_acc[7:0] &&
                    tail[1] == crc_acc[15:8] && tail[0] == cfg_end) ? ST_OK : ST_FAIL;
      end
      v.nbytes = (pairs > 255) ? 8'hFF : pairs[7:0];
      v.crc    = crc_acc;
      clear_frame();
    end
  endtask

  task automatic drive_char(input logic [7:0] ch, input logic known,
                            input frame_verdict_t given);
    logic           done;
    frame_verdict_t calc;
    while ($urandom_range(99, 0) < src_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    absorb_char(ch, done, calc);
    if (done) verdict_q.push_back(known ? given : calc);
    chars_sent++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) drive_char(line_buf[i], 1'b0, '0);
    drive_char(8'h00, 1'b0, '0);
    line_buf.delete();
  endtask

  task automatic build_frame(input int unsigned len, input flaw_t flaw);
    logic [7:0]  fb [];
    logic [15:0] acc;
    fb = new[len];
    foreach (fb[i]) fb[i] = 8'($urandom);
    fb[0] = cfg_start;
    fb[1] = len[7:0];
    acc = CRC_INIT;
    for (int i = 0; i + 3 < len; i++) acc = crc_step(acc, fb[i]);
    fb[len-3] = acc[7:0];
    fb[len-2] = acc[15:8];
    fb[len-1] = cfg_end;
    if (flaw == FLAW_BYTE) fb[$urandom_range(len - 1, 0)] ^= 8'($urandom_range(255, 1));
    foreach (fb[i]) begin
      line_buf.push_back(hex_char(fb[i][7:4], 1'b1));
      line_buf.push_back(hex_char(fb[i][3:0], 1'b0));
    end
    if (flaw == FLAW_CUT) begin
      void'(line_buf.pop_back());
    end else if (flaw == FLAW_EXTRA) begin
      line_buf.insert($urandom_range(line_buf.size() - 1, 0), 8'($urandom_range(255, 1)));
    end
  endtask

  task automatic random_frame();
    int unsigned pick;
    flaw_t       flaw;
    pick = $urandom_range(99, 0);
    flaw = ($urandom_range(99, 0) < 20) ?
           flaw_t'($urandom_range(FLAW_EXTRA, FLAW_BYTE)) : FLAW_NONE;
    if (pick < 2) begin
      build_frame($urandom_range(128, 120), FLAW_NONE);
      while (line_buf.size() <= MAX_CHARS_DEF) line_buf.push_back(8'($urandom_range(255, 1)));
    end else if (pick < 5) begin
      build_frame($urandom_range(128, 40), flaw);
    end else if (pick < 20) begin
      repeat ($urandom_range(30, 0)) line_buf.push_back(8'($urandom_range(255, 1)));
    end else begin
      build_frame($urandom_range(16, 3), flaw);
    end
    send_line();
  endtask

  task automatic settle_input();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write, then read back over the same select
  task automatic set_reg(input logic [2:0] addr, input logic [7:0] val);
    logic [7:0] got;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= {24'($urandom), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    if (addr == ADDR_START) cfg_start = val;
    else cfg_end = val;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    got = cfg_prdata[7:0];
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== val) note_mismatch($sformatf("reg 0x%0h read 0x%02h, wrote 0x%02h",
                                             addr, got, val));
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= sink_stall);
  end

  always @(posedge clk) begin
    frame_verdict_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (verdict_q.size() == 0) begin
        note_mismatch("result beat with no frame pending");
      end else begin
        want = verdict_q.pop_front();
        if (out_tdata[1:0] !== want.status)
          note_mismatch($sformatf("status %0d, want %0d", out_tdata[1:0], want.status));
        if (out_tdata[9:2] !== want.nbytes)
          note_mismatch($sformatf("frame_bytes %0d, want %0d", out_tdata[9:2], want.nbytes));
        if (out_tdata[25:10] !== want.crc)
          note_mismatch($sformatf("crc 0x%04h, want 0x%04h", out_tdata[25:10], want.crc));
        if (out_tdata[8*OUT_BYTES-1:OUT_BITS] !== '0)
          note_mismatch("nonzero pad bits in result beat");
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int unsigned phase_mark;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (script[i]) drive_char(script[i].ch, script[i].known, script[i].v);

    // overflow keeps reporting the bytes held; then a full-length good frame
    build_frame(128, FLAW_NONE);
    repeat (3) line_buf.push_back(8'($urandom_range(255, 1)));
    send_line();
    build_frame(128, FLAW_NONE);
    send_line();

    for (int p = 0; p < 4; p++) begin
      settle_input();
      case (p)
        0: begin
          set_reg(ADDR_START, 8'h00);
          set_reg(ADDR_END, 8'hFF);
          src_idle   = 0;
          sink_stall = 0;
        end
        1: begin
          set_reg(ADDR_START, 8'hFF);
          set_reg(ADDR_END, 8'h00);
          src_idle   = 64;
          sink_stall = 0;
        end
        2: begin
          set_reg(ADDR_START, 8'($urandom));
          set_reg(ADDR_END, 8'($urandom));
          src_idle   = 0;
          sink_stall = 64;
        end
        default: begin
          set_reg(ADDR_START, START_RST);
          set_reg(ADDR_END, END_RST);
          src_idle   = 11;
          sink_stall = 11;
        end
      endcase
      phase_mark = chars_sent;
      while (chars_sent - phase_mark < PHASE_CHARS) random_frame();
    end

    settle_input();
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: files.f
design/hafc_pkg.sv
design/hex_ascii_frame_checker_core.sv
test/tb_top.sv
